### sv/fpr_pkg.sv
// shared types and constants for the framed packet receiver
// no dependencies; imported by every module of the block
package fpr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = IDX_W + 1;
  // one bank bit selects between two payload buffers
  localparam int ADDR_W      = IDX_W + 1;
  localparam int DQ_DEPTH    = 2;
  localparam int DQ_PTR_W    = $clog2(DQ_DEPTH);
  localparam int DQ_CNT_W    = DQ_PTR_W + 1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd165;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd90;
  localparam logic [7:0] VERSION_RST     = 8'd1;
  localparam logic [6:0] LIMIT_RST       = 7'd64;

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_VERSION     = 2'd2,
    CFG_LIMIT       = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_SYNC0,
    PH_SYNC1,
    PH_VERSION,
    PH_TYPE,
    PH_LEN0,
    PH_LEN1,
    PH_PAYLOAD,
    PH_SUM
  } phase_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] version;
    logic [6:0] limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       ftype;
    logic [LEN_W-1:0] len;
    logic             bank;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic busy;
    logic bank;
  } back_stat_t;

  typedef struct packed {
    logic [7:0]       ftype;
    logic [LEN_W-1:0] len;
    logic             has_data;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
  } res_t;

endpackage

### sv/fpr_front.sv
// front parser: sync hunt, header checks, running sum and payload writes
// depends on fpr_pkg; feeds fpr_desc_q and the payload buffer in fpr_back
module fpr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  fpr_pkg::cfg_t cfg,
  input  logic          take,
  input  logic [7:0]    in_byte,
  output logic          desc_push,
  output fpr_pkg::desc_t desc,
  output fpr_pkg::wr_t  wr
);
  import fpr_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic             bank_r, bank_nxt;
  logic [LEN_W-1:0] eff_limit;
  logic [LEN_W-1:0] fill_inc;
  logic [7:0]       sum_add;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC0;
      sum_r   <= '0;
      type_r  <= '0;
      lo_r    <= '0;
      len_r   <= '0;
      fill_r  <= '0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      type_r  <= type_nxt;
      lo_r    <= lo_nxt;
      len_r   <= len_nxt;
      fill_r  <= fill_nxt;
      bank_r  <= bank_nxt;
    end
  end

  always_comb begin
    eff_limit = (LEN_W'(cfg.limit) > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                          : LEN_W'(cfg.limit);
    fill_inc  = fill_r + LEN_W'(1);
    sum_add   = sum_r + in_byte;

    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    type_nxt  = type_r;
    lo_nxt    = lo_r;
    len_nxt   = len_r;
    fill_nxt  = fill_r;
    bank_nxt  = bank_r;
    desc_push = 1'b0;
    desc      = '{ftype: type_r, len: len_r, bank: bank_r};
    wr        = '{en: 1'b0, addr: {bank_r, fill_r[IDX_W-1:0]}, data: in_byte};

    if (take) begin
      unique case (phase_r)
        PH_SYNC0: begin
          if (in_byte == cfg.sync_first) phase_nxt = PH_SYNC1;
        end
        PH_SYNC1: begin
          // second sync wins; a repeated first sync keeps waiting
          if (in_byte == cfg.sync_second) begin
            phase_nxt = PH_VERSION;
            sum_nxt   = '0;
            fill_nxt  = '0;
          end else if (in_byte != cfg.sync_first) begin
            phase_nxt = PH_SYNC0;
          end
        end
        PH_VERSION: begin
          if (in_byte != cfg.version) begin
            phase_nxt = PH_SYNC0;
          end else begin
            sum_nxt   = sum_add;
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_nxt  = in_byte;
          sum_nxt   = sum_add;
          phase_nxt = PH_LEN0;
        end
        PH_LEN0: begin
          lo_nxt    = in_byte;
          sum_nxt   = sum_add;
          phase_nxt = PH_LEN1;
        end
        PH_LEN1: begin
          sum_nxt = sum_add;
          // high length byte nonzero is always over the limit
          if ((in_byte != 8'd0) || (lo_r > {1'b0, eff_limit})) begin
            phase_nxt = PH_SYNC0;
          end else begin
            len_nxt   = lo_r[LEN_W-1:0];
            phase_nxt = (lo_r == 8'd0) ? PH_SUM : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          wr.en    = 1'b1;
          fill_nxt = fill_inc;
          sum_nxt  = sum_add;
          if (fill_inc >= len_r) phase_nxt = PH_SUM;
        end
        PH_SUM: begin
          if (in_byte == sum_r) begin
            desc_push = 1'b1;
            bank_nxt  = ~bank_r;
          end
          phase_nxt = PH_SYNC0;
        end
        default: phase_nxt = PH_SYNC0;
      endcase
    end
  end

endmodule

### sv/fpr_desc_q.sv
// short queue of accepted packet descriptors between parser and emitter
// depends on fpr_pkg
module fpr_desc_q (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  fpr_pkg::desc_t           push_desc,
  input  logic                     pop,
  output fpr_pkg::desc_t           head,
  output logic                     not_empty,
  output logic [fpr_pkg::DQ_CNT_W-1:0] count
);
  import fpr_pkg::*;

  desc_t                ent_r [DQ_DEPTH];
  logic [DQ_PTR_W-1:0]  wp_r, wp_nxt;
  logic [DQ_PTR_W-1:0]  rp_r, rp_nxt;
  logic [DQ_CNT_W-1:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_desc;
  end

  always_comb begin
    wp_nxt  = push ? wp_r + DQ_PTR_W'(1) : wp_r;
    rp_nxt  = pop ? rp_r + DQ_PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + DQ_CNT_W'(push) - DQ_CNT_W'(pop);
  end

  assign head      = ent_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule

### sv/fpr_back.sv
// back end: two-bank payload buffer and the result emitter with its output queue
// depends on fpr_pkg; takes descriptors from fpr_desc_q, writes from fpr_front
module fpr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  fpr_pkg::wr_t        wr,
  input  logic                desc_valid,
  input  fpr_pkg::desc_t      desc,
  output logic                desc_pop,
  output fpr_pkg::back_stat_t stat,
  output fpr_pkg::res_t       res,
  output logic                res_empty,
  input  logic                res_pop
);
  import fpr_pkg::*;

  logic [7:0]       mem_r [2*MAX_PAYLOAD];
  logic [7:0]       rd_q_r;

  back_state_t      st_r, st_nxt;
  desc_t            cur_r, cur_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;
  logic             pv_r;
  res_t             pm_r, pm_nxt;
  res_t             fifo_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [1:0]       room;
  logic             issue, last_i, push, pop;
  res_t             push_res;

  always_ff @(posedge clk) begin
    if (wr.en) mem_r[wr.addr] <= wr.data;
    if (issue) rd_q_r <= mem_r[{cur_r.bank, k_r[IDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= BK_IDLE;
      k_r   <= '0;
      pv_r  <= 1'b0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
      cur_r <= '0;
    end else begin
      st_r  <= st_nxt;
      k_r   <= k_nxt;
      pv_r  <= issue;
      wp_r  <= wp_r ^ push;
      rp_r  <= rp_r ^ pop;
      cnt_r <= cnt_nxt;
      cur_r <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pm_r <= pm_nxt;
    if (push) fifo_r[wp_r] <= push_res;
  end

  always_comb begin
    // in-flight read counts against output room
    room     = cnt_r + {1'b0, pv_r};
    issue    = (st_r == BK_RUN) && (room < 2'd2);
    last_i   = (cur_r.len == '0) || ((k_r + LEN_W'(1)) == cur_r.len);
    desc_pop = 1'b0;
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    k_nxt    = k_r;

    unique case (st_r)
      BK_IDLE: begin
        if (desc_valid) begin
          desc_pop = 1'b1;
          cur_nxt  = desc;
          k_nxt    = '0;
          st_nxt   = BK_RUN;
        end
      end
      BK_RUN: begin
        if (issue) begin
          k_nxt = k_r + LEN_W'(1);
          if (last_i) st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase

    pm_nxt          = '0;
    pm_nxt.ftype    = cur_r.ftype;
    pm_nxt.len      = cur_r.len;
    pm_nxt.has_data = (cur_r.len != '0);
    pm_nxt.idx      = k_r[IDX_W-1:0];
    pm_nxt.last     = last_i;

    push_res      = pm_r;
    push_res.data = pm_r.has_data ? rd_q_r : 8'd0;
    push          = pv_r;
    pop           = res_pop && (cnt_r != 2'd0);
    cnt_nxt       = cnt_r + {1'b0, push} - {1'b0, pop};

    stat.busy = (st_r == BK_RUN);
    stat.bank = cur_r.bank;
  end

  assign res       = fifo_r[rp_r];
  assign res_empty = (cnt_r == 2'd0);

endmodule

### sv/framed_packet_receiver_top.sv
// framed packet receiver: parser takes one byte per cycle while input is not full;
// a good packet's results follow its sum byte through the descriptor queue, buffer read
// and output queue; the emitter reads on only while the output queue has room.
// input is held full while two accepted packets own both payload banks (queued or draining).
// reset (rst_n low, synchronous) returns the parser to the sync hunt, empties both queues
// and restores register defaults; payload buffer contents are not cleared
module framed_packet_receiver_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_frame_type,
  output logic [6:0] out_frame_length,
  output logic       out_has_data,
  output logic [7:0] out_data_byte,
  output logic [5:0] out_byte_index,
  output logic       out_last
);
  import fpr_pkg::*;

  cfg_t                cfg_r, cfg_nxt;
  logic                take;
  logic                desc_push, desc_pop, desc_valid;
  desc_t               desc_in, desc_head;
  logic [DQ_CNT_W-1:0] q_cnt;
  wr_t                 wr;
  back_stat_t          stat;
  res_t                res;
  logic [DQ_CNT_W:0]   owned;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{sync_first: SYNC_FIRST_RST, sync_second: SYNC_SECOND_RST,
                 version: VERSION_RST, limit: LIMIT_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SYNC_FIRST:  cfg_nxt.sync_first  = cfg_data;
        CFG_SYNC_SECOND: cfg_nxt.sync_second = cfg_data;
        CFG_VERSION:     cfg_nxt.version     = cfg_data;
        CFG_LIMIT:       cfg_nxt.limit       = cfg_data[6:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  // each queued or draining packet owns one payload bank
  assign owned   = {1'b0, q_cnt} + (DQ_CNT_W+1)'(stat.busy);
  assign in_full = (owned >= (DQ_CNT_W+1)'(2));
  assign take    = in_push && !in_full;

  fpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .take      (take),
    .in_byte   (in_byte),
    .desc_push (desc_push),
    .desc      (desc_in),
    .wr        (wr)
  );

  fpr_desc_q u_desc_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .push_desc (desc_in),
    .pop       (desc_pop),
    .head      (desc_head),
    .not_empty (desc_valid),
    .count     (q_cnt)
  );

  fpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .desc_valid (desc_valid),
    .desc       (desc_head),
    .desc_pop   (desc_pop),
    .stat       (stat),
    .res        (res),
    .res_empty  (out_empty),
    .res_pop    (out_pop)
  );

  assign out_frame_type   = res.ftype;
  assign out_frame_length = res.len;
  assign out_has_data     = res.has_data;
  assign out_data_byte    = res.data;
  assign out_byte_index   = res.idx;
  assign out_last         = res.last;

  a_no_desc_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    desc_push |-> (q_cnt < DQ_CNT_W'(DQ_DEPTH)))
    else $error("descriptor queue overflow");

  a_bank_isolation : assert property (@(posedge clk) disable iff (!rst_n)
    (wr.en && stat.busy) |-> (wr.addr[ADDR_W-1] != stat.bank))
    else $error("payload write into the bank being drained");

  a_no_write_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !wr.en && !desc_push)
    else $error("parser acted while input full");

  a_empty_after_reset : assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("results pending right after reset");

endmodule

### bench/fpr_deframe_checker.sv
// checker for the framed packet receiver: mirrors the deframer one byte at a time
// and compares each popped result with the oldest predicted one; depends on fpr_pkg
module fpr_deframe_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_push,
  input  logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic [7:0] out_frame_type,
  input  logic [6:0] out_frame_length,
  input  logic       out_has_data,
  input  logic [7:0] out_data_byte,
  input  logic [5:0] out_byte_index,
  input  logic       out_last,
  output int         errors,
  output int         pending,
  output int         packets,
  output int         results
);
  import fpr_pkg::*;

  // register copies
  logic [7:0]  sync_a;
  logic [7:0]  sync_b;
  logic [7:0]  want_ver;
  logic [6:0]  len_limit;

  // parser copy
  phase_t      ph;
  logic [7:0]  sum;
  logic [7:0]  held_type;
  logic [15:0] held_len;
  logic [6:0]  fill;
  logic [7:0]  payload_mem [MAX_PAYLOAD];

  res_t        deframed_q [$];
  res_t        head_r;
  int          err_cnt = 0;
  int          pkt_cnt = 0;
  int          res_cnt = 0;

  task automatic clear_frame();
    ph        = PH_SYNC0;
    sum       = 8'h00;
    held_type = 8'h00;
    held_len  = 16'h0000;
    fill      = 7'd0;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    res_t r;
    int   lim;
    lim = (len_limit < MAX_PAYLOAD) ? len_limit : MAX_PAYLOAD;
    case (ph)
      PH_SYNC0: begin
        if (b == sync_a) ph = PH_SYNC1;
      end
      PH_SYNC1: begin
        // second sync is tested first, a repeated first sync keeps waiting
        if (b == sync_b) begin
          ph       = PH_VERSION;
          sum      = 8'h00;
          fill     = 7'd0;
          held_len = 16'h0000;
        end else if (b != sync_a) begin
          ph = PH_SYNC0;
        end
      end
      PH_VERSION: begin
        if (b != want_ver) begin
          clear_frame();
        end else begin
          sum = sum + b;
          ph  = PH_TYPE;
        end
      end
      PH_TYPE: begin
        held_type = b;
        sum       = sum + b;
        ph        = PH_LEN0;
      end
      PH_LEN0: begin
        held_len = {8'h00, b};
        sum      = sum + b;
        ph       = PH_LEN1;
      end
      PH_LEN1: begin
        held_len = {b, held_len[7:0]};
        sum      = sum + b;
        if (held_len > lim) clear_frame();
        else if (held_len == 0) ph = PH_SUM;
        else ph = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (fill < MAX_PAYLOAD) payload_mem[fill[5:0]] = b;
        fill = fill + 7'd1;
        sum  = sum + b;
        if (fill >= held_len) ph = PH_SUM;
      end
      default: begin
        if (b == sum) begin
          if (held_len == 0) begin
            // empty payload gives a single notice
            r = '{ftype: held_type, len: '0, has_data: 1'b0, data: 8'h00,
                  idx: '0, last: 1'b1};
            deframed_q.push_back(r);
          end else begin
            for (int k = 0; k < held_len; k++) begin
              r.ftype    = held_type;
              r.len      = held_len[6:0];
              r.has_data = 1'b1;
              r.data     = payload_mem[k[5:0]];
              r.idx      = k[5:0];
              r.last     = (k == held_len - 1);
              deframed_q.push_back(r);
            end
          end
        end
        clear_frame();
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sync_a    = SYNC_FIRST_RST;
      sync_b    = SYNC_SECOND_RST;
      want_ver  = VERSION_RST;
      len_limit = LIMIT_RST;
      clear_frame();
      deframed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_FIRST:  sync_a    = cfg_data;
          CFG_SYNC_SECOND: sync_b    = cfg_data;
          CFG_VERSION:     want_ver  = cfg_data;
          CFG_LIMIT:       len_limit = cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        res_cnt++;
        if (out_last) pkt_cnt++;
        if (deframed_q.size() == 0) begin
          $error("result with nothing pending: type %h index %0d data %h",
                 out_frame_type, out_byte_index, out_data_byte);
          err_cnt++;
        end else begin
          head_r = deframed_q.pop_front();
          check_field("frame_type", head_r.ftype, out_frame_type);
          check_field("frame_length", 8'(head_r.len), 8'(out_frame_length));
          check_field("has_data", 8'(head_r.has_data), 8'(out_has_data));
          check_field("data_byte", head_r.data, out_data_byte);
          check_field("byte_index", 8'(head_r.idx), 8'(out_byte_index));
          check_field("last", 8'(head_r.last), 8'(out_last));
        end
      end
      if (in_push && !in_full) deframe_byte(in_byte);
    end
    errors  <= err_cnt;
    pending <= deframed_q.size();
    packets <= pkt_cnt;
    results <= res_cnt;
  end

endmodule

### bench/tb.sv
// testbench top for the framed packet receiver: sends framed byte streams and
// register settings, pops results; checking is done in fpr_deframe_checker (fpr_pkg)
module tb;
  import fpr_pkg::*;

  typedef enum {FR_GOOD, FR_BAD_VERSION, FR_BAD_SUM, FR_TOO_LONG} frame_kind_t;

  localparam int QUIET_LIMIT  = 1000;
  localparam int SETTLE_WAIT  = 12;
  localparam int DRAIN_CYCLES = 20;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = CFG_SYNC_FIRST;
  logic [7:0] cfg_data  = 8'h00;
  logic       in_push   = 1'b0;
  logic       in_full;
  logic [7:0] in_byte   = 8'h00;
  logic       out_empty;
  logic       out_pop   = 1'b0;
  logic [7:0] out_frame_type;
  logic [6:0] out_frame_length;
  logic       out_has_data;
  logic [7:0] out_data_byte;
  logic [5:0] out_byte_index;
  logic       out_last;

  int errors;
  int pending;
  int packets;
  int results;

  logic       calm = 1'b0;
  int         bytes_sent = 0;
  int         settings = 1;
  int         quiet = 0;
  logic [7:0] cur_sf  = SYNC_FIRST_RST;
  logic [7:0] cur_ss  = SYNC_SECOND_RST;
  logic [7:0] cur_ver = VERSION_RST;
  logic [6:0] cur_lim = LIMIT_RST;

  framed_packet_receiver_top dut (.*);
  fpr_deframe_checker checker_i (.*);

  always #5 clk = ~clk;

  always @(posedge clk) out_pop <= calm || ($urandom_range(0, 99) >= 10);

  // watchdog on cycles with no accepted request on either side
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_kind_t kind, input logic [7:0] ftype,
                            input logic [15:0] len);
    logic [7:0] fb [$];
    logic [7:0] ver;
    logic [7:0] s;
    logic [7:0] d;
    ver = (kind == FR_BAD_VERSION) ? cur_ver ^ 8'($urandom_range(1, 255)) : cur_ver;
    fb  = '{cur_sf, cur_ss, ver, ftype, len[7:0], len[15:8]};
    s   = ver + ftype + len[7:0] + len[15:8];
    if (kind == FR_BAD_VERSION) fb = fb[0:2];
    if (kind == FR_GOOD || kind == FR_BAD_SUM) begin
      for (int i = 0; i < len; i++) begin
        d = 8'($urandom);
        fb.push_back(d);
        s = s + d;
      end
      fb.push_back((kind == FR_BAD_SUM) ? s + 8'($urandom_range(1, 255)) : s);
    end
    foreach (fb[i]) push_byte(fb[i]);
  endtask

  // hold the sender until every predicted result has been popped
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] sf, input logic [7:0] ss,
                               input logic [7:0] ver, input logic [6:0] lim);
    cfg_idx_t   regs [4];
    logic [7:0] vals [4];
    regs = '{CFG_SYNC_FIRST, CFG_SYNC_SECOND, CFG_VERSION, CFG_LIMIT};
    vals = '{sf, ss, ver, {1'b0, lim}};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cur_sf  = sf;
    cur_ss  = ss;
    cur_ver = ver;
    cur_lim = lim;
    settings++;
  endtask

  // mostly well-formed frames with short payloads, plus broken frames and noise
  task automatic random_traffic(input int budget);
    int          start;
    int          pick;
    int          eff;
    int          n;
    logic [15:0] len;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      eff  = (cur_lim < MAX_PAYLOAD) ? cur_lim : MAX_PAYLOAD;
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        len = ($urandom_range(0, 9) == 0) ? 16'(eff)
                                          : 16'($urandom_range(0, (eff < 6) ? eff : 6));
        send_frame(FR_GOOD, 8'($urandom), len);
      end else if (pick < 80) begin
        send_frame(FR_BAD_VERSION, 8'($urandom), 16'd0);
      end else if (pick < 88) begin
        send_frame(FR_BAD_SUM, 8'($urandom), 16'($urandom_range(0, (eff < 4) ? eff : 4)));
      end else if (pick < 94) begin
        len = $urandom_range(0, 1) ? 16'(eff + 1 + $urandom_range(0, 3))
                                   : 16'($urandom_range(256, 65535));
        send_frame(FR_TOO_LONG, 8'($urandom), len);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) push_byte($urandom_range(0, 1) ? cur_sf : 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // repeated first sync ahead of an empty packet, then each way a frame fails
    push_byte(cur_sf);
    send_frame(FR_GOOD, 8'h00, 16'd0);
    send_frame(FR_BAD_VERSION, 8'h00, 16'd0);
    send_frame(FR_BAD_SUM, 8'hFF, 16'd1);
    send_frame(FR_TOO_LONG, 8'h80, 16'd65);
    random_traffic(20);

    load_settings(8'hFF, 8'h00, 8'h00, 7'd0);
    random_traffic(20);

    // limit above the buffer depth, no idling on either side
    load_settings(8'h00, 8'hFF, 8'hFF, 7'd127);
    calm <= 1'b1;
    send_frame(FR_GOOD, 8'h5A, 16'(MAX_PAYLOAD));
    send_frame(FR_TOO_LONG, 8'hA5, 16'(MAX_PAYLOAD + 1));
    random_traffic(20);
    calm <= 1'b0;

    // both sync bytes equal
    load_settings(8'h3C, 8'h3C, 8'h80, 7'd8);
    random_traffic(20);

    load_settings(8'($urandom), 8'($urandom), 8'($urandom),
                  7'($urandom_range(1, MAX_PAYLOAD)));
    random_traffic(20);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bytes under %0d register settings", bytes_sent, settings);
    $display("compared %0d results from %0d packets", results, packets);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
